// ===== hdl/ps2kd_pkg.sv =====
// Shared types, constants and the layout table of the PS/2 set 1 key decoder.
package ps2kd_pkg;

    // Key and bitmap geometry
    localparam int KEY_COUNT = 128;
    localparam int KEY_W     = 7;
    localparam int MAP_DEPTH = 2 * KEY_COUNT;
    localparam int MAP_AW    = KEY_W + 1;

    // Scancode bytes and key numbers of interest
    localparam logic [7:0]       SC_PREFIX  = 8'hE0;
    localparam logic [KEY_W-1:0] SC_LSHIFT  = 7'h2A;
    localparam logic [KEY_W-1:0] SC_RSHIFT  = 7'h36;
    localparam logic [KEY_W-1:0] SC_CTRL    = 7'h1D;
    localparam logic [KEY_W-1:0] SC_CAPS    = 7'h3A;
    localparam logic [KEY_W-1:0] SC_UP      = 7'h48;
    localparam logic [KEY_W-1:0] SC_DOWN    = 7'h50;
    localparam logic [KEY_W-1:0] SC_LEFT    = 7'h4B;
    localparam logic [KEY_W-1:0] SC_RIGHT   = 7'h4D;
    localparam logic [KEY_W-1:0] SC_COMMA   = 7'h33;
    localparam logic [KEY_W-1:0] SC_PERIOD  = 7'h34;
    localparam logic [KEY_W-1:0] SC_SLASH   = 7'h35;
    localparam logic [KEY_W-1:0] SC_CTRL_LO = 7'h10;
    localparam logic [KEY_W-1:0] SC_CTRL_HI = 7'h35;

    // Character codes
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_CASE    = 8'h20;

    // Reset values of the code registers
    localparam logic [7:0] RST_CODE_UP    = 8'd240;
    localparam logic [7:0] RST_CODE_DOWN  = 8'd241;
    localparam logic [7:0] RST_CODE_LEFT  = 8'd242;
    localparam logic [7:0] RST_CODE_RIGHT = 8'd243;
    localparam logic [7:0] RST_CODE_ENTER = 8'd10;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_POP   = 2'd1,
        OP_QUERY = 2'd2,
        OP_FLUSH = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UP    = 3'd0,
        CFG_DOWN  = 3'd1,
        CFG_LEFT  = 3'd2,
        CFG_RIGHT = 3'd3,
        CFG_ENTER = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_code;
        logic       key_is_down;
        logic       shift_state;
        logic       caps_state;
        logic [7:0] last_code;
        logic       fifo_nonempty;
    } result_t;

    // Turkish Q layout: shifted code in bits 15..8, normal code in bits 7..0
    function automatic logic [15:0] layout_lookup(input logic [KEY_W-1:0] sc);
        logic [15:0] e;
        begin
            case (sc)
                7'h01:   e = 16'h001B;
                7'h02:   e = 16'h2131;
                7'h03:   e = 16'h2732;
                7'h04:   e = 16'h5E33;
                7'h05:   e = 16'h2B34;
                7'h06:   e = 16'h2535;
                7'h07:   e = 16'h2636;
                7'h08:   e = 16'h2F37;
                7'h09:   e = 16'h2838;
                7'h0A:   e = 16'h2939;
                7'h0B:   e = 16'h3D30;
                7'h0C:   e = 16'h3F2A;
                7'h0D:   e = 16'h5F2D;
                7'h0E:   e = 16'h0008;
                7'h0F:   e = 16'h0009;
                7'h10:   e = 16'h5171;
                7'h11:   e = 16'h5777;
                7'h12:   e = 16'h4565;
                7'h13:   e = 16'h5272;
                7'h14:   e = 16'h5474;
                7'h15:   e = 16'h5979;
                7'h16:   e = 16'h5575;
                7'h17:   e = 16'h988D;
                7'h18:   e = 16'h4F6F;
                7'h19:   e = 16'h5070;
                7'h1A:   e = 16'hA6A7;
                7'h1B:   e = 16'h9A81;
                7'h1C:   e = 16'h000A;
                7'h1E:   e = 16'h4161;
                7'h1F:   e = 16'h5373;
                7'h20:   e = 16'h4464;
                7'h21:   e = 16'h4666;
                7'h22:   e = 16'h4767;
                7'h23:   e = 16'h4868;
                7'h24:   e = 16'h4A6A;
                7'h25:   e = 16'h4B6B;
                7'h26:   e = 16'h4C6C;
                7'h27:   e = 16'h9E9F;
                7'h28:   e = 16'h9869;
                7'h29:   e = 16'hE922;
                7'h2B:   e = 16'h3E3C;
                7'h2C:   e = 16'h5A7A;
                7'h2D:   e = 16'h5878;
                7'h2E:   e = 16'h4363;
                7'h2F:   e = 16'h5676;
                7'h30:   e = 16'h4262;
                7'h31:   e = 16'h4E6E;
                7'h32:   e = 16'h4D6D;
                7'h33:   e = 16'h9994;
                7'h34:   e = 16'h8087;
                7'h35:   e = 16'h3A2E;
                7'h39:   e = 16'h0020;
                default: e = 16'h0000;
            endcase
            return e;
        end
    endfunction

    // Swap case of the CP857 letters outside ASCII
    function automatic logic [7:0] cp857_case_swap(input logic [7:0] c);
        logic [7:0] r;
        begin
            case (c)
                8'h8D:   r = 8'h98;
                8'h98:   r = 8'h8D;
                8'hA7:   r = 8'hA6;
                8'hA6:   r = 8'hA7;
                8'h81:   r = 8'h9A;
                8'h9A:   r = 8'h81;
                8'h9F:   r = 8'h9E;
                8'h9E:   r = 8'h9F;
                8'h94:   r = 8'h99;
                8'h99:   r = 8'h94;
                8'h87:   r = 8'h80;
                8'h80:   r = 8'h87;
                default: r = c;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== hdl/ps2kd_if.sv =====
// Channel interfaces of the key decoder: scancode items, results, register writes.
interface ps2kd_scan_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       aux_flag;
    logic [6:0] key_index;
    logic       key_extended;

    modport source (output valid, opcode, data_byte, aux_flag, key_index, key_extended,
                    input ready);
    modport sink   (input valid, opcode, data_byte, aux_flag, key_index, key_extended,
                    output ready);
endinterface

interface ps2kd_result_if;
    logic       valid;
    logic       ready;
    logic       char_valid;
    logic [7:0] char_code;
    logic       key_is_down;
    logic       shift_state;
    logic       caps_state;
    logic [7:0] last_code;
    logic       fifo_nonempty;

    modport source (output valid, char_valid, char_code, key_is_down, shift_state,
                    caps_state, last_code, fifo_nonempty, input ready);
    modport sink   (input valid, char_valid, char_code, key_is_down, shift_state,
                    caps_state, last_code, fifo_nonempty, output ready);
endinterface

interface ps2kd_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/ps2kd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
module ps2kd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port: data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ps2_set1_keycode_decoder.sv =====
// Top level of the PS/2 scancode set 1 to character decoder.
//
//  channel | modport | transfer moves
//  --------+---------+-------------------------------------------------------------
//  scan    | sink    | opcode, data_byte, aux_flag, key_index, key_extended
//  result  | source  | char_valid, char_code, key_is_down, shift_state, caps_state,
//          |         | last_code, fifo_nonempty
//  cfg     | sink    | index (register number), data (8-bit code); always ready
//
//  One item per cycle while scan.ready is high. An item updates all control state at its
//  transfer edge, and the same edge registers its read of the character FIFO RAM or the
//  key bitmap RAM into the read stage; the output register loads from the read stage
//  when the read stage advances, and result valid rises with that load.
//  Reset clears pointers, modifiers, prefix, last code and all bitmap valid bits at
//  once; there is no clearing pass. A stalled result holds the output register, then
//  the read stage, and scan.ready drops only when both are full and the result is not
//  taken.
module ps2_set1_keycode_decoder
    import ps2kd_pkg::*;
#(
    parameter int FIFO_DEPTH = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    ps2kd_scan_if.sink     scan,
    ps2kd_result_if.source result,
    ps2kd_cfg_if.sink      cfg
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    // Code registers
    logic [7:0] code_up_reg, code_down_reg, code_left_reg, code_right_reg, code_enter_reg;

    // Control state
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic             shift_reg, shift_next;
    logic             ctrl_reg, ctrl_next;
    logic             caps_reg, caps_next;
    logic             prefix_reg, prefix_next;
    logic [7:0]       last_reg, last_next;
    logic [MAP_DEPTH-1:0] map_vld_reg;

    // Read stage and output register
    logic       s1_valid_reg;
    logic       s1_pop_reg, s1_pop_next;
    logic       s1_query_reg, s1_query_next;
    logic       s1_qvld_reg;
    logic       s1_shift_reg, s1_caps_reg, s1_nonempty_reg;
    logic [7:0] s1_last_reg;
    logic       out_valid_reg;
    result_t    out_reg;

    // Handshake and memory control
    logic             scan_xfer, s1_advance;
    op_t              op;
    logic             released;
    logic [KEY_W-1:0] sc;
    logic [7:0]       xlat;
    logic             push_req;
    logic [7:0]       push_data;
    logic             fifo_full, fifo_empty;
    logic             fifo_we, fifo_re;
    logic [7:0]       fifo_rdata;
    logic             map_we, map_re, map_clear;
    logic [MAP_AW-1:0] map_waddr, map_raddr;
    logic [0:0]       map_wdata, map_rdata;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign op         = op_t'(scan.opcode);
    assign s1_advance = s1_valid_reg && (!out_valid_reg || result.ready);
    assign scan.ready = !s1_valid_reg || s1_advance;
    assign scan_xfer  = scan.valid && scan.ready;
    assign cfg.ready  = 1'b1;

    assign released   = scan.data_byte[7];
    assign sc         = scan.data_byte[KEY_W-1:0];
    assign fifo_full  = (ptr_inc(wr_ptr_reg) == rd_ptr_reg);
    assign fifo_empty = (wr_ptr_reg == rd_ptr_reg);

    // Translate a plain key press through the layout with shift, ctrl and caps
    always_comb
    begin
        logic [15:0] entry;
        logic [7:0]  base;
        logic [7:0]  c;
        entry = layout_lookup(sc);
        base  = entry[7:0];
        c     = shift_reg ? entry[15:8] : base;
        if (sc == SC_COMMA)
        begin
            xlat = shift_reg ? 8'h3C : 8'h2C;
        end
        else if (sc == SC_PERIOD)
        begin
            xlat = shift_reg ? 8'h3E : 8'h2E;
        end
        else if (sc == SC_SLASH)
        begin
            xlat = shift_reg ? 8'h3F : 8'h2F;
        end
        else if (c == 8'h00)
        begin
            xlat = 8'h00;
        end
        else if (ctrl_reg && sc >= SC_CTRL_LO && sc <= SC_CTRL_HI
                 && base >= CH_LOWER_A && base <= CH_LOWER_Z)
        begin
            xlat = base - CH_LOWER_A + 8'd1;
        end
        else if (ctrl_reg && sc >= SC_CTRL_LO && sc <= SC_CTRL_HI
                 && base >= CH_UPPER_A && base <= CH_UPPER_Z)
        begin
            xlat = base - CH_UPPER_A + 8'd1;
        end
        else if (shift_reg || !caps_reg)
        begin
            xlat = c;
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
        begin
            xlat = c - CH_CASE;
        end
        else if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            xlat = c + CH_CASE;
        end
        else
        begin
            xlat = cp857_case_swap(c);
        end
    end

    // Decode the accepted item: next control state, RAM writes and reads
    always_comb
    begin
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        shift_next    = shift_reg;
        ctrl_next     = ctrl_reg;
        caps_next     = caps_reg;
        prefix_next   = prefix_reg;
        last_next     = last_reg;
        push_req      = 1'b0;
        push_data     = xlat;
        map_we        = 1'b0;
        map_waddr     = {1'b0, sc};
        map_wdata     = ~released;
        map_clear     = 1'b0;
        map_re        = 1'b0;
        map_raddr     = {scan.key_extended, scan.key_index};
        fifo_re       = 1'b0;
        s1_pop_next   = 1'b0;
        s1_query_next = 1'b0;
        if (scan_xfer)
        begin
            case (op)
                OP_BYTE:
                begin
                    if (!scan.aux_flag)
                    begin
                        last_next = scan.data_byte;
                        if (scan.data_byte == SC_PREFIX)
                        begin
                            prefix_next = 1'b1;
                        end
                        else if (prefix_reg)
                        begin
                            // Extended key: track it and map the arrows
                            prefix_next = 1'b0;
                            map_we      = 1'b1;
                            map_waddr   = {1'b1, sc};
                            if (!released)
                            begin
                                if (sc == SC_UP)
                                begin
                                    push_req  = 1'b1;
                                    push_data = code_up_reg;
                                end
                                else if (sc == SC_DOWN)
                                begin
                                    push_req  = 1'b1;
                                    push_data = code_down_reg;
                                end
                                else if (sc == SC_LEFT)
                                begin
                                    push_req  = 1'b1;
                                    push_data = code_left_reg;
                                end
                                else if (sc == SC_RIGHT)
                                begin
                                    push_req  = 1'b1;
                                    push_data = code_right_reg;
                                end
                            end
                        end
                        else if (sc == SC_LSHIFT || sc == SC_RSHIFT)
                        begin
                            shift_next = ~released;
                        end
                        else if (sc == SC_CTRL)
                        begin
                            ctrl_next = ~released;
                        end
                        else if (sc == SC_CAPS && !released)
                        begin
                            caps_next = ~caps_reg;
                        end
                        else
                        begin
                            // Plain key: track it and push its character on press
                            map_we = 1'b1;
                            if (!released && xlat != 8'h00)
                            begin
                                push_req  = 1'b1;
                                push_data = (xlat == CH_NEWLINE) ? code_enter_reg : xlat;
                            end
                        end
                    end
                end
                OP_POP:
                begin
                    if (!fifo_empty)
                    begin
                        fifo_re     = 1'b1;
                        s1_pop_next = 1'b1;
                        rd_ptr_next = ptr_inc(rd_ptr_reg);
                    end
                end
                OP_QUERY:
                begin
                    map_re        = 1'b1;
                    s1_query_next = 1'b1;
                end
                OP_FLUSH:
                begin
                    wr_ptr_next = '0;
                    rd_ptr_next = '0;
                    map_clear   = 1'b1;
                end
                default:
                begin
                    map_clear = 1'b0;
                end
            endcase
        end
        // Drop the character when the FIFO is full
        fifo_we = push_req && !fifo_full;
        if (fifo_we)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
        end
    end

    // Character FIFO storage
    ps2kd_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (wr_ptr_reg),
        .wdata (push_data),
        .re    (fifo_re),
        .raddr (rd_ptr_reg),
        .rdata (fifo_rdata)
    );

    // Pressed-key bitmaps, extended keys in the upper half
    ps2kd_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // Code registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_up_reg    <= RST_CODE_UP;
            code_down_reg  <= RST_CODE_DOWN;
            code_left_reg  <= RST_CODE_LEFT;
            code_right_reg <= RST_CODE_RIGHT;
            code_enter_reg <= RST_CODE_ENTER;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_UP:    code_up_reg    <= cfg.data;
                CFG_DOWN:  code_down_reg  <= cfg.data;
                CFG_LEFT:  code_left_reg  <= cfg.data;
                CFG_RIGHT: code_right_reg <= cfg.data;
                CFG_ENTER: code_enter_reg <= cfg.data;
                default:   code_enter_reg <= code_enter_reg;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            shift_reg  <= 1'b0;
            ctrl_reg   <= 1'b0;
            caps_reg   <= 1'b0;
            prefix_reg <= 1'b0;
            last_reg   <= 8'h00;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            shift_reg  <= shift_next;
            ctrl_reg   <= ctrl_next;
            caps_reg   <= caps_next;
            prefix_reg <= prefix_next;
            last_reg   <= last_next;
        end
    end

    // Bitmap valid bits: an entry never written since reset or flush reads as released
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_vld_reg <= '0;
        end
        else if (map_clear)
        begin
            map_vld_reg <= '0;
        end
        else if (map_we)
        begin
            map_vld_reg[map_waddr] <= 1'b1;
        end
    end

    // Read stage and output register occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (scan_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Read stage payload: status after the step, waiting for RAM data
    always_ff @(posedge clk)
    begin
        if (scan_xfer)
        begin
            s1_pop_reg      <= s1_pop_next;
            s1_query_reg    <= s1_query_next;
            s1_qvld_reg     <= map_vld_reg[map_raddr];
            s1_shift_reg    <= shift_next;
            s1_caps_reg     <= caps_next;
            s1_last_reg     <= last_next;
            s1_nonempty_reg <= (wr_ptr_next != rd_ptr_next);
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_reg.char_valid    <= s1_pop_reg;
            out_reg.char_code     <= s1_pop_reg ? fifo_rdata : 8'h00;
            out_reg.key_is_down   <= s1_query_reg && s1_qvld_reg && map_rdata[0];
            out_reg.shift_state   <= s1_shift_reg;
            out_reg.caps_state    <= s1_caps_reg;
            out_reg.last_code     <= s1_last_reg;
            out_reg.fifo_nonempty <= s1_nonempty_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.char_valid    = out_reg.char_valid;
    assign result.char_code     = out_reg.char_code;
    assign result.key_is_down   = out_reg.key_is_down;
    assign result.shift_state   = out_reg.shift_state;
    assign result.caps_state    = out_reg.caps_state;
    assign result.last_code     = out_reg.last_code;
    assign result.fifo_nonempty = out_reg.fifo_nonempty;

    // Pointers stay inside the ring
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ptr_reg <= PTR_LAST && rd_ptr_reg <= PTR_LAST)
        else $error("FIFO pointer out of range");

    // A flush leaves the FIFO empty
    a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
        scan_xfer && op == OP_FLUSH |=> wr_ptr_reg == rd_ptr_reg)
        else $error("FIFO not empty after flush");

    // A pop and a query never share one result
    a_pop_query: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.char_valid && result.key_is_down))
        else $error("result carries both a character and a key state");

    // No character code without a popped character
    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.char_valid |-> result.char_code == 8'h00)
        else $error("character code without a pop");

    // A stalled read stage keeps its item
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_pop_reg)
            && $stable(s1_query_reg))
        else $error("read stage lost its item under stall");

endmodule
